>>> rtl/core/dtk_pkg.sv
// Shared types and constants for the debounced transport key block.
// Used by the channel interfaces, the top level and the port checker.
package dtk_pkg;

  localparam int unsigned NUM_KEYS = 4;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 32;

  // Register reset value: debounce time in microseconds
  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd20000;

  // Key roles
  localparam logic [1:0] KEY_PLAY = 2'd0;
  localparam logic [1:0] KEY_NEXT = 2'd1;
  localparam logic [1:0] KEY_UP   = 2'd2;
  localparam logic [1:0] KEY_DOWN = 2'd3;

  // LED patterns
  localparam logic [NUM_KEYS-1:0] LED_PLAYING = 4'hF;
  localparam logic [NUM_KEYS-1:0] LED_IDLE    = 4'h1;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_STOP   = 1'b1
  } op_t;

  typedef struct packed {
    logic                operation;
    logic [NUM_KEYS-1:0] keys_down;
    logic [TIME_W-1:0]   now_us;
  } sample_t;

  typedef struct packed {
    logic                playing;
    logic [NUM_KEYS-1:0] led_mask;
    logic                request_playback;
    logic                up_event;
    logic                up_pressed;
    logic                down_event;
    logic                down_pressed;
    logic [COUNT_W-1:0]  next_count;
    logic [COUNT_W-1:0]  play_count;
  } result_t;

endpackage

>>> rtl/core/dtk_channels.sv
// Valid/ready channel interfaces for key samples and transport results.
// Depends on dtk_pkg for the payload structs.
interface dtk_sample_if;
  logic             valid;
  logic             ready;
  dtk_pkg::sample_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
  modport mon    (input valid, input payload, input ready);
endinterface

interface dtk_result_if;
  logic             valid;
  logic             ready;
  dtk_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
  modport mon    (input valid, input payload, input ready);
endinterface

>>> rtl/core/debounced_transport_keys.sv
// Debounced transport keys: four key samples in, one transport result out per request.
// Depends on dtk_pkg and the channel interfaces in dtk_channels.sv.
// Each result is registered in the output register, or in the skid entry on an output stall.
// Throughput: one request per cycle while the skid is empty; a two-entry output stage (register
// plus skid) keeps the input open for one more request while a result waits to be taken.
// Reset (rst, synchronous): keys released, change times zero, play on, counters zero,
// debounce time 20000 us, output stage empty.
module debounced_transport_keys (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dtk_pkg::TIME_W-1:0]   cfg_wdata,
  dtk_sample_if.sink                   sample,
  dtk_result_if.source                 result
);

  localparam int unsigned NK = dtk_pkg::NUM_KEYS;

  // Block state
  logic [dtk_pkg::TIME_W-1:0]  debounce_time;
  logic [NK-1:0]               raw_levels;
  logic [NK-1:0]               stable_levels;
  logic [dtk_pkg::TIME_W-1:0]  change_times [NK];
  logic                        play_flag;
  logic [dtk_pkg::COUNT_W-1:0] next_counter;
  logic [dtk_pkg::COUNT_W-1:0] play_counter;

  // Output stage
  logic             res_valid;
  dtk_pkg::result_t res_data;
  logic             skid_valid;
  dtk_pkg::result_t skid_data;

  logic accept;
  logic is_stop;

  // Per-key next values
  logic [NK-1:0]               keys;
  logic [dtk_pkg::TIME_W-1:0]  now;
  logic [dtk_pkg::TIME_W-1:0]  change_times_next [NK];
  logic [NK-1:0]               flip;
  logic [NK-1:0]               stable_levels_next;

  // Transport decisions
  logic                        play_flag_next;
  logic                        play_on;
  logic                        play_off;
  logic                        next_hit;
  logic                        up_hit;
  logic                        down_hit;
  logic [dtk_pkg::COUNT_W-1:0] next_counter_next;
  logic [dtk_pkg::COUNT_W-1:0] play_counter_next;
  dtk_pkg::result_t            res_next;

  assign accept  = sample.valid && sample.ready;
  assign is_stop = (sample.payload.operation == dtk_pkg::OP_STOP);
  assign keys    = sample.payload.keys_down;
  assign now     = sample.payload.now_us;

  // Track raw changes and test each key's hold time against the debounce time
  for (genvar gi = 0; gi < NK; gi++) begin : g_key
    logic [dtk_pkg::TIME_W-1:0] elapsed;
    assign change_times_next[gi] = (keys[gi] != raw_levels[gi]) ? now : change_times[gi];
    assign elapsed               = now - change_times_next[gi];
    assign flip[gi]              = (elapsed >= debounce_time) &&
                                   (keys[gi] != stable_levels[gi]);
  end

  assign stable_levels_next = stable_levels ^ flip;

  // Key 0 toggles play; keys 1 to 3 act under the play state it leaves
  always_comb begin
    play_on  = 1'b0;
    play_off = 1'b0;
    if (flip[dtk_pkg::KEY_PLAY] && keys[dtk_pkg::KEY_PLAY]) begin
      play_on  = !play_flag;
      play_off = play_flag;
    end
    play_flag_next = play_flag ^ (play_on || play_off);
    next_hit = play_flag_next && flip[dtk_pkg::KEY_NEXT] && keys[dtk_pkg::KEY_NEXT];
    up_hit   = play_flag_next && flip[dtk_pkg::KEY_UP];
    down_hit = play_flag_next && flip[dtk_pkg::KEY_DOWN];
    next_counter_next = next_counter + dtk_pkg::COUNT_W'(next_hit);
    play_counter_next = play_counter + dtk_pkg::COUNT_W'(play_on);
  end

  // Build the result for the request at the input
  always_comb begin
    if (is_stop) begin
      res_next.playing          = 1'b0;
      res_next.led_mask         = dtk_pkg::LED_IDLE;
      res_next.request_playback = 1'b0;
      res_next.up_event         = 1'b1;
      res_next.up_pressed       = 1'b0;
      res_next.down_event       = 1'b1;
      res_next.down_pressed     = 1'b0;
      res_next.next_count       = next_counter;
      res_next.play_count       = play_counter;
    end else begin
      res_next.playing          = play_flag_next;
      res_next.led_mask         = play_flag_next ? dtk_pkg::LED_PLAYING : dtk_pkg::LED_IDLE;
      res_next.request_playback = play_on;
      res_next.up_event         = play_off || up_hit;
      res_next.up_pressed       = up_hit && keys[dtk_pkg::KEY_UP];
      res_next.down_event       = play_off || down_hit;
      res_next.down_pressed     = down_hit && keys[dtk_pkg::KEY_DOWN];
      res_next.next_count       = next_counter_next;
      res_next.play_count       = play_counter_next;
    end
  end

  // Write the debounce time register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= dtk_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_time <= cfg_wdata;
    end
  end

  // Advance key and transport state on each accepted sample; a stop only turns play off
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_levels    <= '0;
      stable_levels <= '0;
      play_flag     <= 1'b1;
      next_counter  <= '0;
      play_counter  <= '0;
      for (int k = 0; k < NK; k++) begin
        change_times[k] <= '0;
      end
    end else if (accept) begin
      if (is_stop) begin
        play_flag <= 1'b0;
      end else begin
        raw_levels    <= keys;
        stable_levels <= stable_levels_next;
        play_flag     <= play_flag_next;
        next_counter  <= next_counter_next;
        play_counter  <= play_counter_next;
        for (int k = 0; k < NK; k++) begin
          change_times[k] <= change_times_next[k];
        end
      end
    end
  end

  // Output register with one skid entry behind it
  assign sample.ready   = !skid_valid;
  assign result.valid   = res_valid;
  assign result.payload = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || result.ready) begin
      res_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || result.ready) begin
      res_data <= skid_valid ? skid_data : res_next;
    end
    if (res_valid && !result.ready && accept) begin
      skid_data <= res_next;
    end
  end

endmodule

>>> rtl/core/dtk_port_checker.sv
// Port-level checks for debounced_transport_keys, attached by bind.
// Depends on dtk_pkg and the channel interfaces in dtk_channels.sv.
module dtk_port_checker (
  input  logic          clk,
  input  logic          rst,
  dtk_sample_if.sink    sample,
  dtk_result_if.source  result
);

  // LED pattern follows the play state
  a_led_matches_play: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.payload.led_mask ==
      (result.payload.playing ? dtk_pkg::LED_PLAYING : dtk_pkg::LED_IDLE)))
    else $error("led_mask does not match playing");

  // A playback request only comes with play on
  a_request_needs_play: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload.request_playback) |-> result.payload.playing)
    else $error("request_playback while not playing");

  // A press flag never stands without its event
  a_press_needs_event: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((!result.payload.up_pressed || result.payload.up_event) &&
                      (!result.payload.down_pressed || result.payload.down_event)))
    else $error("pressed flag set without event");

  // A stalled result holds its payload
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && $stable(result.payload)))
    else $error("stalled result changed");

  // A taken request leaves a result waiting on the next cycle
  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> result.valid)
    else $error("accepted request produced no result");

endmodule

bind debounced_transport_keys dtk_port_checker u_dtk_port_checker (
  .clk    (clk),
  .rst    (rst),
  .sample (sample),
  .result (result)
);

>>> tb/debounced_transport_keys_tb.sv
// Self-checking testbench for debounced_transport_keys: directed key and stop sequences,
// then random debounced key traffic under several idle mixes and a long output hold-off.
// Depends on dtk_pkg, the channel interfaces in dtk_channels.sv and the block itself.
module debounced_transport_keys_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtk_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 40;
  localparam int unsigned DRAIN_CYCLES    = 3;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_wdata;

  dtk_sample_if sample_ch ();
  dtk_result_if result_ch ();

  debounced_transport_keys uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  // Predictor copy of the key and transport state
  logic [TIME_W-1:0]   debounce_us;
  logic [NUM_KEYS-1:0] key_raw;
  logic [NUM_KEYS-1:0] key_stable;
  logic [TIME_W-1:0]   change_at [NUM_KEYS];
  logic                play_on;
  logic [COUNT_W-1:0]  next_total;
  logic [COUNT_W-1:0]  play_total;

  result_t           expected_results [$];
  int unsigned       error_count;
  int unsigned       gap_pct;
  int unsigned       stall_pct;
  int unsigned       hold_left;
  event              hold_go;
  logic [TIME_W-1:0] sample_clock;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(20_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Work out the transport result of one request and advance the predictor state
  function automatic result_t predict_transport(input sample_t s);
    result_t           r;
    logic              down;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    if (s.operation == OP_STOP) begin
      play_on = 1'b0;
      r.up_event = 1'b1;
      r.down_event = 1'b1;
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        down = s.keys_down[k];
        if (down != key_raw[k]) begin
          key_raw[k] = down;
          change_at[k] = s.now_us;
        end
        elapsed = s.now_us - change_at[k];
        if (elapsed < debounce_us) continue;
        if (down == key_stable[k]) continue;
        key_stable[k] = down;
        if (2'(k) == KEY_PLAY && down) begin
          play_on = !play_on;
          if (play_on) begin
            play_total = play_total + 1'b1;
            r.request_playback = 1'b1;
          end else begin
            r.up_event = 1'b1;
            r.up_pressed = 1'b0;
            r.down_event = 1'b1;
            r.down_pressed = 1'b0;
          end
        end else if (play_on && 2'(k) == KEY_NEXT && down) begin
          next_total = next_total + 1'b1;
        end else if (play_on && 2'(k) == KEY_UP) begin
          r.up_event = 1'b1;
          r.up_pressed = down;
        end else if (play_on && 2'(k) == KEY_DOWN) begin
          r.down_event = 1'b1;
          r.down_pressed = down;
        end
      end
    end
    r.playing = play_on;
    r.led_mask = play_on ? LED_PLAYING : LED_IDLE;
    r.next_count = next_total;
    r.play_count = play_total;
    return r;
  endfunction

  function automatic int unsigned field_mismatch(input string name, input logic [31:0] want,
                                                 input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Count down a receiver hold-off once it is triggered
  initial begin
    hold_left = 0;
    forever begin
      @(hold_go);
      hold_left <= HOLD_OFF_CYCLES;
      repeat (HOLD_OFF_CYCLES) begin
        @(posedge clk);
        hold_left <= hold_left - 1;
      end
    end
  end

  // Check each taken result against the oldest prediction, then pick the next ready
  always @(posedge clk) begin : result_check
    result_t     want;
    int unsigned fails;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result taken with no request outstanding");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        fails = field_mismatch("playing", 32'(want.playing), 32'(result_ch.payload.playing))
          + field_mismatch("led_mask", 32'(want.led_mask), 32'(result_ch.payload.led_mask))
          + field_mismatch("request_playback", 32'(want.request_playback),
                           32'(result_ch.payload.request_playback))
          + field_mismatch("up_event", 32'(want.up_event), 32'(result_ch.payload.up_event))
          + field_mismatch("up_pressed", 32'(want.up_pressed),
                           32'(result_ch.payload.up_pressed))
          + field_mismatch("down_event", 32'(want.down_event),
                           32'(result_ch.payload.down_event))
          + field_mismatch("down_pressed", 32'(want.down_pressed),
                           32'(result_ch.payload.down_pressed))
          + field_mismatch("next_count", want.next_count, result_ch.payload.next_count)
          + field_mismatch("play_count", want.play_count, result_ch.payload.play_count);
        if (fails != 0) error_count++;
      end
    end
    result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // Offer one request after a random gap, hold it until taken, then predict its result
  task automatic send_sample(input op_t op, input logic [NUM_KEYS-1:0] keys,
                             input logic [TIME_W-1:0] at_us);
    sample_t s;
    s.operation = op;
    s.keys_down = keys;
    s.now_us = at_us;
    while ($urandom_range(99) < gap_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.payload <= s;
    do @(posedge clk); while (!sample_ch.ready);
    expected_results.push_back(predict_transport(s));
  endtask

  // Drop valid and wait for every outstanding result, then let the block settle
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [TIME_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_us = value;
  endtask

  // Walk through play toggling, key roles, stop and the debounce extremes
  task automatic test_directed_keys();
    gap_pct = 0;
    stall_pct = 0;
    send_sample(OP_SAMPLE, 4'h0, 32'd0);
    send_sample(OP_SAMPLE, 4'h1, 32'd100);
    // one microsecond short of the debounce time: no change yet
    send_sample(OP_SAMPLE, 4'h1, 32'd20099);
    // play key press while playing: turn play off and release both volume keys
    send_sample(OP_SAMPLE, 4'h1, 32'd20100);
    // play key release: level update only
    send_sample(OP_SAMPLE, 4'h0, 32'd20200);
    send_sample(OP_SAMPLE, 4'h0, 32'd40200);
    // play key press while stopped: play on and playback request
    send_sample(OP_SAMPLE, 4'h1, 32'd40300);
    send_sample(OP_SAMPLE, 4'h1, 32'd60300);
    // next press and both volume presses while playing
    send_sample(OP_SAMPLE, 4'hF, 32'd60400);
    send_sample(OP_SAMPLE, 4'hF, 32'd80400);
    // next release does nothing; volume releases are reported
    send_sample(OP_SAMPLE, 4'h1, 32'd80500);
    send_sample(OP_SAMPLE, 4'h1, 32'd100500);
    // stop ignores its key and time fields, and repeats while already stopped
    send_sample(OP_STOP, 4'hF, 32'hFFFF_FFFF);
    send_sample(OP_STOP, 4'h0, 32'd0);
    // other keys while stopped: levels only
    send_sample(OP_SAMPLE, 4'hE, 32'd100600);
    send_sample(OP_SAMPLE, 4'hE, 32'd120600);
    // zero debounce: changes settle on the same sample
    write_debounce(32'd0);
    send_sample(OP_SAMPLE, 4'h1, 32'hFFFF_FFFF);
    send_sample(OP_SAMPLE, 4'hF, 32'd0);
    // full-scale debounce: only a wrapped difference of all ones settles
    write_debounce(32'hFFFF_FFFF);
    send_sample(OP_SAMPLE, 4'h0, 32'd5);
    send_sample(OP_SAMPLE, 4'h0, 32'd4);
    send_sample(OP_SAMPLE, 4'h0, 32'd3);
  endtask

  // Hold random key patterns over random time steps, with bounce, stops and noise mixed in
  task automatic test_random_keys(input int unsigned count, input logic [TIME_W-1:0] debounce,
                                  input int unsigned gap, input int unsigned stall,
                                  input logic [TIME_W-1:0] start_us);
    logic [NUM_KEYS-1:0] pattern;
    logic [NUM_KEYS-1:0] keys;
    int unsigned         hold_samples;
    int unsigned         pick;
    int unsigned         step_max;
    write_debounce(debounce);
    gap_pct = gap;
    stall_pct = stall;
    sample_clock = start_us;
    pattern = key_raw;
    hold_samples = 0;
    step_max = (debounce == 0) ? 64 : debounce + debounce / 2;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_sample(OP_STOP, 4'($urandom), $urandom);
      end else if (pick < 12) begin
        send_sample(OP_SAMPLE, 4'($urandom), $urandom);
      end else begin
        if (hold_samples == 0) begin
          if ($urandom_range(3) == 0) pattern = 4'($urandom);
          else pattern[$urandom_range(NUM_KEYS - 1)] ^= 1'b1;
          hold_samples = $urandom_range(4, 1);
        end
        hold_samples--;
        keys = pattern;
        // contact bounce on one key for a single sample
        if ($urandom_range(9) == 0) keys[$urandom_range(NUM_KEYS - 1)] ^= 1'b1;
        sample_clock += $urandom_range(step_max, 0);
        send_sample(OP_SAMPLE, keys, sample_clock);
      end
    end
  endtask

  // Hold off the receiver while requests come, drain all results, then send more with stalls
  task automatic test_output_backpressure();
    write_debounce(32'd60);
    gap_pct = 0;
    stall_pct = 0;
    -> hold_go;
    for (int n = 0; n < 24; n++) begin
      sample_clock += 40;
      send_sample(OP_SAMPLE, 4'(n >> 2), sample_clock);
    end
    wait_idle();
    stall_pct = 50;
    for (int n = 0; n < 16; n++) begin
      sample_clock += 40;
      send_sample(OP_SAMPLE, 4'($urandom), sample_clock);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.payload = '0;
    result_ch.ready = 1'b0;
    error_count = 0;
    gap_pct = 0;
    stall_pct = 0;
    sample_clock = '0;
    debounce_us = DEBOUNCE_RESET;
    key_raw = '0;
    key_stable = '0;
    foreach (change_at[k]) change_at[k] = '0;
    play_on = 1'b1;
    next_total = '0;
    play_total = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_keys();
    test_random_keys(110, 32'd150, 0, 0, 32'h0001_0000);
    test_random_keys(110, 32'd1000, 70, 0, 32'hFFFF_0000);
    test_random_keys(110, 32'd20000, 0, 70, 32'h8000_0000);
    test_random_keys(110, 32'd7, 36, 36, 32'hFFFF_FFC0);
    test_output_backpressure();
    wait_idle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> debounced_transport_keys.f
rtl/core/dtk_pkg.sv
rtl/core/dtk_channels.sv
rtl/core/debounced_transport_keys.sv
rtl/core/dtk_port_checker.sv
tb/debounced_transport_keys_tb.sv
